// ----- hdl/gs2d_pkg.sv -----
// shared types and constants of the 2-d gaussian smoothing block
package gs2d_pkg;

    localparam int PIX_W   = 16;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int GEO_W   = 13;
    localparam int RAD_W   = 2;
    localparam int WGT_W   = 16;
    localparam int TAP_W   = 32;
    localparam int PROD_W  = 49;
    localparam int ACC_W   = 56;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int MAX_HEIGHT  = 4096;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_RAD_H  = 3'd2,
        REG_RAD_V  = 3'd3,
        REG_WGT_H  = 3'd4,
        REG_WGT_V  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [GEO_W-1:0] width;
        logic [GEO_W-1:0] height;
        logic [RAD_W-1:0] rad_h;
        logic [RAD_W-1:0] rad_v;
    } t_geom;

    typedef struct packed {
        logic             interior;
        logic             border;
        logic             eop;
        logic [ROW_W-1:0] int_row;
        logic [COL_W-1:0] int_col;
        logic [ROW_W-1:0] brd_row;
        logic [COL_W-1:0] brd_col;
    } t_meta;

endpackage

// ----- hdl/gs2d_front.sv -----
// front end: pixel counters, classification and line store
module gs2d_front import gs2d_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_geom                              i_geom,
    input  logic                               i_restart,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [PIX_W-1:0]            i_pixel_in,
    input  logic                               i_q_full,
    output logic                               o_push,
    output t_meta                              o_meta,
    output logic [2*MAX_RADIUS:0][PIX_W-1:0]   o_column
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LINES = 2 * MAX_RADIUS;
    localparam int SW    = $clog2(LINES);
    localparam int XW    = GEO_W + 1;

    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic [SW-1:0]    r_slot;
    logic             r_s1_vld;
    t_meta            r_s1_meta;
    logic [PIX_W-1:0] r_s1_px;
    logic [SW-1:0]    r_s1_slot;
    logic [PIX_W-1:0] r_rd [LINES];

    logic             accept;
    logic             last_col;
    logic             last_row;
    logic [XW-1:0]    row_x;
    logic [XW-1:0]    col_x;
    logic [XW-1:0]    rx_x;
    logic [XW-1:0]    ry_x;
    logic [CW-1:0]    icol;
    logic [CW+COL_W-1:0] icol_ext;
    logic [CW+COL_W-1:0] bcol_ext;
    t_meta            meta;

    assign o_in_stall = r_s1_vld && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_s1_vld && !i_q_full;
    assign o_meta     = r_s1_meta;

    always_comb begin
        row_x    = XW'(r_row);
        col_x    = XW'(r_col);
        rx_x     = XW'(i_geom.rad_h);
        ry_x     = XW'(i_geom.rad_v);
        last_col = col_x == XW'(i_geom.width) - XW'(1);
        last_row = row_x == XW'(i_geom.height) - XW'(1);
        icol     = r_col - CW'(i_geom.rad_h);
        icol_ext = {{COL_W{1'b0}}, icol};
        bcol_ext = {{COL_W{1'b0}}, r_col};
        meta.interior = (row_x >= (ry_x << 1)) && (col_x >= (rx_x << 1));
        meta.border   = (row_x < ry_x) || (row_x + ry_x >= XW'(i_geom.height)) ||
                        (col_x < rx_x) || (col_x + rx_x >= XW'(i_geom.width));
        meta.eop      = last_row && last_col;
        meta.int_row  = r_row - ROW_W'(i_geom.rad_v);
        meta.int_col  = icol_ext[COL_W-1:0];
        meta.brd_row  = r_row;
        meta.brd_col  = bcol_ext[COL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (i_restart) begin
                r_row  <= '0;
                r_col  <= '0;
                r_slot <= '0;
            end else if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + ROW_W'(1);
                        r_slot <= (r_slot == SW'(LINES - 1)) ? '0 : r_slot + SW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (o_push) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= meta;
            r_s1_px   <= i_pixel_in;
            r_s1_slot <= r_slot;
        end
    end

    for (genvar g = 0; g < LINES; g++) begin : g_bank
        logic [PIX_W-1:0] mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_rd[g] <= mem[r_col];
                if (r_slot == SW'(g)) begin
                    mem[r_col] <= i_pixel_in;
                end
            end
        end
    end

    always_comb begin
        logic [SW:0] s;
        s = '0;
        o_column[0] = r_s1_px;
        for (int d = 1; d <= LINES; d++) begin
            s = {1'b0, r_s1_slot} + (SW+1)'(LINES - d);
            if (s >= (SW+1)'(LINES)) begin
                s = s - (SW+1)'(LINES);
            end
            o_column[d] = r_rd[s[SW-1:0]];
        end
    end

endmodule

// ----- hdl/gs2d_queue.sv -----
// short fifo between the front end and the arithmetic back end
module gs2d_queue import gs2d_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [PW:0]       r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hdl/gs2d_back.sv -----
// back end: window registers, tap multipliers, adder tree and result output
module gs2d_back import gs2d_pkg::*; #(
    parameter int MAX_RADIUS = 3
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_geom                                   i_geom,
    input  logic [CFG_W-1:0]                        i_wgt_h,
    input  logic [CFG_W-1:0]                        i_wgt_v,
    input  logic                                    i_q_valid,
    input  logic [$bits(t_meta)+PIX_W*(2*MAX_RADIUS+1)-1:0] i_q_data,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [ROW_W-1:0]                        o_row_out,
    output logic [COL_W-1:0]                        o_column_out,
    output logic signed [PIX_W-1:0]                 o_pixel_out,
    output logic                                    o_last_of_item,
    output logic                                    o_end_of_plane
);

    localparam int SPAN = 2 * MAX_RADIUS + 1;
    localparam int NT   = MAX_RADIUS + 1;
    localparam int TI   = $clog2(NT);
    localparam int CV_W = PIX_W * SPAN;

    logic [TAP_W-1:0]          r_tap [NT][NT];
    logic [TAP_W-1:0]          r_wt  [SPAN][SPAN];
    logic                      r_use [SPAN][SPAN];
    logic signed [PIX_W-1:0]   r_win [SPAN][SPAN];
    logic signed [PROD_W-1:0]  r_prod [SPAN][SPAN];
    logic signed [ACC_W-1:0]   r_rsum [SPAN];
    logic signed [ACC_W-1:0]   r_sum;

    logic  r_v1, r_v2, r_v3, r_v4;
    t_meta r_m1, r_m2, r_m3, r_m4;

    logic                    r_ov;
    logic                    r_sent;
    t_meta                   r_om;
    logic signed [PIX_W-1:0] r_oval;

    t_meta                        q_meta;
    logic [SPAN-1:0][PIX_W-1:0]   q_col;
    logic                         take;
    logic                         emit_int;
    logic                         out_last;
    logic                         en;
    logic signed [ACC_W-1:0]      total;
    logic signed [ACC_W-1:0]      rs [SPAN];

    function automatic logic signed [PIX_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
        logic             neg;
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        neg = s[ACC_W-1];
        mag = neg ? ACC_W'(-s) : ACC_W'(s);
        q   = (mag + (ACC_W'(1) << 29)) >> 30;
        if (neg) begin
            round_sat = (q > ACC_W'(32768)) ? PIX_W'(16'sh8000) : PIX_W'(-q);
        end else begin
            round_sat = (q > ACC_W'(32767)) ? PIX_W'(16'sh7fff) : PIX_W'(q);
        end
    endfunction

    assign q_meta = i_q_data[$bits(t_meta)+CV_W-1 -: $bits(t_meta)];
    assign q_col  = i_q_data[CV_W-1:0];

    assign emit_int = r_om.interior && !r_sent;
    assign out_last = !(emit_int && r_om.border);
    assign take     = r_ov && !i_out_stall;
    assign en       = !r_ov || (take && out_last);
    assign o_pop    = en && i_q_valid;

    assign o_out_valid    = r_ov;
    assign o_row_out      = emit_int ? r_om.int_row : r_om.brd_row;
    assign o_column_out   = emit_int ? r_om.int_col : r_om.brd_col;
    assign o_pixel_out    = emit_int ? r_oval : '0;
    assign o_last_of_item = out_last;
    assign o_end_of_plane = r_om.eop;

    // separable tap weights, refreshed every cycle from the weight registers
    for (genvar j = 0; j < NT; j++) begin : g_tap_y
        for (genvar i = 0; i < NT; i++) begin : g_tap_x
            always_ff @(posedge i_clk) begin
                r_tap[j][i] <= i_wgt_v[WGT_W*j +: WGT_W] * i_wgt_h[WGT_W*i +: WGT_W];
            end
        end
    end

    for (genvar a = 0; a < SPAN; a++) begin : g_wt_y
        for (genvar b = 0; b < SPAN; b++) begin : g_wt_x
            logic [2:0] da;
            logic [2:0] db;
            always_comb begin
                da = (3'(a) >= 3'(i_geom.rad_v)) ? 3'(a) - 3'(i_geom.rad_v)
                                                 : 3'(i_geom.rad_v) - 3'(a);
                db = (3'(b) >= 3'(i_geom.rad_h)) ? 3'(b) - 3'(i_geom.rad_h)
                                                 : 3'(i_geom.rad_h) - 3'(b);
            end
            always_ff @(posedge i_clk) begin
                r_wt[a][b]  <= r_tap[da[TI-1:0]][db[TI-1:0]];
                r_use[a][b] <= (3'(a) <= {i_geom.rad_v, 1'b0}) &&
                               (3'(b) <= {i_geom.rad_h, 1'b0});
            end
        end
    end

    always_comb begin
        for (int a = 0; a < SPAN; a++) begin
            rs[a] = '0;
            for (int b = 0; b < SPAN; b++) begin
                rs[a] = rs[a] + ACC_W'(r_prod[a][b]);
            end
        end
        total = '0;
        for (int a = 0; a < SPAN; a++) begin
            total = total + r_rsum[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int d = 0; d < SPAN; d++) begin
                for (int k = SPAN - 1; k > 0; k--) begin
                    r_win[d][k] <= r_win[d][k-1];
                end
                r_win[d][0] <= q_col[d];
            end
        end
        if (en) begin
            r_m1 <= q_meta;
            r_m2 <= r_m1;
            r_m3 <= r_m2;
            r_m4 <= r_m3;
            for (int a = 0; a < SPAN; a++) begin
                for (int b = 0; b < SPAN; b++) begin
                    r_prod[a][b] <= r_use[a][b] ? r_win[a][b] * $signed({1'b0, r_wt[a][b]})
                                                : $signed(PROD_W'(0));
                end
                r_rsum[a] <= rs[a];
            end
            r_sum <= total;
            r_om  <= r_m4;
            r_oval <= round_sat(r_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_ov   <= 1'b0;
            r_sent <= 1'b0;
        end else begin
            if (en) begin
                r_v1 <= o_pop;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
            end
            if (en && r_v4 && (r_m4.interior || r_m4.border)) begin
                r_ov   <= 1'b1;
                r_sent <= 1'b0;
            end else if (take) begin
                if (!out_last) begin
                    r_sent <= 1'b1;
                end else begin
                    r_ov <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- hdl/gaussian_smooth_2d.sv -----
// top level of the streaming 2-d gaussian smoothing block
//
// Pixels enter on the input channel (i_in_valid, o_in_stall, i_pixel_in) in
// raster order, one plane after another. Each pixel causes zero, one or two
// results on the output channel: the lagged interior pixel first, then a
// zero for the current position when it lies on the border. Every result
// carries its own row and column; o_last_of_item marks the final result of a
// pixel and o_end_of_plane marks results of the last pixel of a plane.
// One pixel is taken per cycle while the output takes one result per cycle;
// a pixel with two results holds the back end until both are taken. The
// front end (counters, six line-store memories read together) and the
// multiply and adder tree back end are joined by a four-entry fifo, so a
// stall on the output fills the fifo before o_in_stall rises. Configuration
// writes use i_cfg_valid and o_cfg_ready and are taken any cycle; geometry
// writes restart the plane. Reset restores the default geometry, clears
// counters and drains all pipeline stages; the line store is not cleared.
module gaussian_smooth_2d import gs2d_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [PIX_W-1:0] i_pixel_in,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ROW_W-1:0]        o_row_out,
    output logic [COL_W-1:0]        o_column_out,
    output logic signed [PIX_W-1:0] o_pixel_out,
    output logic                    o_last_of_item,
    output logic                    o_end_of_plane
);

    localparam int SPAN = 2 * MAX_RADIUS + 1;
    localparam int QW   = $bits(t_meta) + PIX_W * SPAN;

    logic [FW_W-1:0]  r_width;
    logic [FH_W-1:0]  r_height;
    logic [RAD_W-1:0] r_rad_h;
    logic [RAD_W-1:0] r_rad_v;
    logic [CFG_W-1:0] r_wgt_h;
    logic [CFG_W-1:0] r_wgt_v;

    logic                       cfg_we;
    logic                       restart;
    t_geom                      geom;
    logic                       w_push;
    logic                       w_q_full;
    logic                       w_q_valid;
    logic                       w_pop;
    t_meta                      w_meta;
    logic [SPAN-1:0][PIX_W-1:0] w_column;
    logic [QW-1:0]              w_q_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_we && ((i_cfg_index == REG_WIDTH) || (i_cfg_index == REG_HEIGHT) ||
                                    (i_cfg_index == REG_RAD_H) || (i_cfg_index == REG_RAD_V));

    always_comb begin
        if (r_width == '0) begin
            geom.width = GEO_W'(1);
        end else if (GEO_W'(r_width) > GEO_W'(MAX_WIDTH)) begin
            geom.width = GEO_W'(MAX_WIDTH);
        end else begin
            geom.width = GEO_W'(r_width);
        end
        if (r_height == '0) begin
            geom.height = GEO_W'(1);
        end else if (r_height > FH_W'(MAX_HEIGHT)) begin
            geom.height = GEO_W'(MAX_HEIGHT);
        end else begin
            geom.height = r_height;
        end
        geom.rad_h = (r_rad_h > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_rad_h;
        geom.rad_v = (r_rad_v > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_rad_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FW_W'(640);
            r_height <= FH_W'(480);
            r_rad_h  <= RAD_W'(1);
            r_rad_v  <= RAD_W'(1);
            r_wgt_h  <= '0;
            r_wgt_v  <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data[FW_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[FH_W-1:0];
                REG_RAD_H:  r_rad_h  <= i_cfg_data[RAD_W-1:0];
                REG_RAD_V:  r_rad_v  <= i_cfg_data[RAD_W-1:0];
                REG_WGT_H:  r_wgt_h  <= i_cfg_data;
                REG_WGT_V:  r_wgt_v  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gs2d_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_restart  (restart),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pixel_in (i_pixel_in),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_meta     (w_meta),
        .o_column   (w_column)
    );

    gs2d_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_meta, w_column}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    gs2d_back #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (geom),
        .i_wgt_h        (r_wgt_h),
        .i_wgt_v        (r_wgt_v),
        .i_q_valid      (w_q_valid),
        .i_q_data       (w_q_data),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_row_out      (o_row_out),
        .o_column_out   (o_column_out),
        .o_pixel_out    (o_pixel_out),
        .o_last_of_item (o_last_of_item),
        .o_end_of_plane (o_end_of_plane)
    );

`ifndef NO_ASSERTIONS
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_only_when_queue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_q_full && !w_push))
        else $error("input stalled while queue had room");

    a_second_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_item) |=> (o_out_valid && o_last_of_item))
        else $error("second result of a pixel missing");
`endif

endmodule

// ----- tb/gaussian_smooth_2d_tb.sv -----
// self-checking testbench for the streaming 2-d gaussian smoothing block
`timescale 1ns / 1ps

module gaussian_smooth_2d_tb;
    import gs2d_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam int STORE_ROWS = 6;
    localparam int STORE_COLS = 1024;
    localparam int SPAN = 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TARGET_PIXELS = 1400;

    typedef struct {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [PIX_W-1:0] value;
        logic                    last;
        logic                    eop;
    } t_smooth_result;

    class smooth_scoreboard;
        logic [FW_W-1:0]  frame_w;
        logic [FH_W-1:0]  frame_h;
        logic [RAD_W-1:0] rad_x, rad_y;
        logic [CFG_W-1:0] wgt_x, wgt_y;
        shortint          line_mem[STORE_ROWS*STORE_COLS];
        shortint          win[SPAN][SPAN];
        int unsigned      row_cnt, col_cnt;
        t_smooth_result   pending[$];
        int               errors;

        function new();
            frame_w = 640;
            frame_h = 480;
            rad_x = 1;
            rad_y = 1;
            wgt_x = '0;
            wgt_y = '0;
            row_cnt = 0;
            col_cnt = 0;
            errors = 0;
            foreach (line_mem[i]) line_mem[i] = 0;
            foreach (win[i, j]) win[i][j] = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_WIDTH:  frame_w = data[FW_W-1:0];
                REG_HEIGHT: frame_h = data[FH_W-1:0];
                REG_RAD_H:  rad_x = data[RAD_W-1:0];
                REG_RAD_V:  rad_y = data[RAD_W-1:0];
                REG_WGT_H:  wgt_x = data;
                REG_WGT_V:  wgt_y = data;
                default: ;
            endcase
            if (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_RAD_H || idx == REG_RAD_V) begin
                row_cnt = 0;
                col_cnt = 0;
            end
        endfunction

        function logic signed [PIX_W-1:0] round_to_pixel(longint acc);
            longint mag;
            longint q;
            mag = (acc < 0) ? -acc : acc;
            q = (mag + (64'sd1 <<< 29)) >>> 30;
            if (acc < 0) return (q > 32768) ? -16'sd32768 : PIX_W'(-q);
            return (q > 32767) ? 16'sd32767 : PIX_W'(q);
        endfunction

        function void note_pixel(logic signed [PIX_W-1:0] px);
            int unsigned w, h, rx, ry, r, c, base, slot;
            shortint     fresh[SPAN];
            longint      acc, tap;
            int          n;
            bit          eop, border;
            t_smooth_result res;
            w = (frame_w == 0) ? 1 : ((frame_w > 1024) ? 1024 : frame_w);
            h = (frame_h == 0) ? 1 : ((frame_h > 4096) ? 4096 : frame_h);
            rx = rad_x;
            ry = rad_y;
            r = (row_cnt >= h) ? 0 : row_cnt;
            c = (col_cnt >= w) ? 0 : col_cnt;
            base = r % STORE_ROWS;
            fresh[0] = px;
            for (int d = 1; d < SPAN; d++) begin
                slot = (base + STORE_ROWS - d) % STORE_ROWS;
                fresh[d] = line_mem[slot*STORE_COLS + c];
            end
            for (int d = 0; d < SPAN; d++) begin
                for (int k = SPAN - 1; k > 0; k--) win[d][k] = win[d][k-1];
                win[d][0] = fresh[d];
            end
            line_mem[base*STORE_COLS + c] = px;
            eop = (r == h - 1) && (c == w - 1);
            n = 0;
            if (r >= 2*ry && c >= 2*rx) begin
                acc = 0;
                for (int dy = -int'(ry); dy <= int'(ry); dy++) begin
                    for (int dx = -int'(rx); dx <= int'(rx); dx++) begin
                        tap = longint'(wgt_x[16*((dx < 0) ? -dx : dx) +: 16])
                            * longint'(wgt_y[16*((dy < 0) ? -dy : dy) +: 16]);
                        acc += tap * longint'(win[int'(ry) - dy][int'(rx) - dx]);
                    end
                end
                res.row = ROW_W'(r - ry);
                res.col = COL_W'(c - rx);
                res.value = round_to_pixel(acc);
                res.last = 1'b0;
                res.eop = eop;
                pending.push_back(res);
                n++;
            end
            border = (r < ry) || (r + ry >= h) || (c < rx) || (c + rx >= w);
            if (border) begin
                res.row = ROW_W'(r);
                res.col = COL_W'(c);
                res.value = '0;
                res.last = 1'b0;
                res.eop = eop;
                pending.push_back(res);
                n++;
            end
            if (n > 0) pending[$].last = 1'b1;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            row_cnt = r;
            col_cnt = c;
        endfunction

        function void check_result(t_smooth_result got);
            t_smooth_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d value %0d",
                         $time, got.row, got.col, got.value);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.row !== want.row) begin
                $display("%0t: row_out expected %0d actual %0d", $time, want.row, got.row);
                errors++;
            end
            if (got.col !== want.col) begin
                $display("%0t: column_out expected %0d actual %0d", $time, want.col, got.col);
                errors++;
            end
            if (got.value !== want.value) begin
                $display("%0t: pixel_out at (%0d,%0d) expected %0d actual %0d",
                         $time, want.row, want.col, want.value, got.value);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_of_item expected %0b actual %0b", $time, want.last, got.last);
                errors++;
            end
            if (got.eop !== want.eop) begin
                $display("%0t: end_of_plane expected %0b actual %0b", $time, want.eop, got.eop);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [IDX_W-1:0]        i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [PIX_W-1:0] i_pixel_in;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [ROW_W-1:0]        o_row_out;
    logic [COL_W-1:0]        o_column_out;
    logic signed [PIX_W-1:0] o_pixel_out;
    logic                    o_last_of_item;
    logic                    o_end_of_plane;

    smooth_scoreboard sb;
    bit               quiet;
    int               pixels_sent;
    int               idle_cycles;

    gaussian_smooth_2d dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sink side backpressure
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_smooth_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.row = o_row_out;
            got.col = o_column_out;
            got.value = o_pixel_out;
            got.last = o_last_of_item;
            got.eop = o_end_of_plane;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(logic signed [PIX_W-1:0] px);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pixel_in = px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_weights();
        logic [CFG_W-1:0] wv;
        case ($urandom_range(0, 3))
            0: wv = {$urandom, $urandom};
            1: wv = '1;
            default: begin
                for (int k = 0; k < 4; k++) wv[16*k +: 16] = 16'($urandom_range(0, 16384));
            end
        endcase
        return wv;
    endfunction

    task automatic set_geometry(int w, int h, int rx, int ry);
        write_cfg(REG_WIDTH, CFG_W'(w));
        write_cfg(REG_HEIGHT, CFG_W'(h));
        write_cfg(REG_RAD_H, CFG_W'(rx));
        write_cfg(REG_RAD_V, CFG_W'(ry));
    endtask

    initial begin
        int w, h, count;
        sb = new();
        quiet = 1'b0;
        pixels_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_pixel_in = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default geometry and zero weights straight out of reset
        for (int i = 0; i < 6; i++) send_pixel(random_pixel());
        drain();

        // saturating weights on a 5x5 plane with extreme pixels
        set_geometry(5, 5, 1, 1);
        write_cfg(REG_WGT_H, '1);
        write_cfg(REG_WGT_V, '1);
        for (int i = 0; i < 25; i++) begin
            send_pixel((i % 2 == 0) ? -16'sd32768 : 16'sd32767);
            if (i == 12) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
        end
        drain();

        // zero geometry clamps to a single pixel, radius zero
        set_geometry(0, 0, 0, 0);
        write_cfg(REG_WGT_H, 64'h0000_0000_0000_8000);
        write_cfg(REG_WGT_V, 64'h0000_0000_0000_8000);
        send_pixel(16'sd32767);
        send_pixel(-16'sd32768);
        drain();

        // oversize geometry clamps, frame too small along x for any interior
        set_geometry(2047, 8191, 3, 3);
        write_cfg(REG_UNUSED_LO, '1);
        write_cfg(REG_UNUSED_HI, '1);
        send_pixel(16'sd1);
        send_pixel(-16'sd1);
        drain();
        set_geometry(3, 3, 3, 3);
        for (int i = 0; i < 9; i++) send_pixel(random_pixel());
        drain();

        // weight write mid-plane keeps the position
        set_geometry(4, 4, 1, 0);
        for (int i = 0; i < 6; i++) send_pixel(random_pixel());
        drain();
        write_cfg(REG_WGT_H, random_weights());
        for (int i = 0; i < 10; i++) send_pixel(random_pixel());
        drain();

        // one long row at full width
        set_geometry(1024, 1, 3, 0);
        write_cfg(REG_WGT_H, random_weights());
        for (int i = 0; i < 1024; i++) send_pixel(random_pixel());
        drain();

        while (pixels_sent < TARGET_PIXELS) begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 12);
            set_geometry(w, h, $urandom_range(0, 3), $urandom_range(0, 3));
            write_cfg(REG_WGT_H, random_weights());
            write_cfg(REG_WGT_V, random_weights());
            count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w*h) : w*h*$urandom_range(1, 2);
            for (int i = 0; i < count; i++) begin
                if (pixels_sent >= TARGET_PIXELS) break;
                if (pixels_sent > TARGET_PIXELS - 150) quiet = 1'b1;
                send_pixel(random_pixel());
                if (!quiet && $urandom_range(0, 199) == 0) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
